// ----- hw/rtl/apc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_pkg
// Shared constants, codes and controller/datapath structs of the ADC
// piecewise linear correction block.
// ----------------------------------------------------------------------------
package apc_pkg;

    // map store geometry
    localparam int BOARDS     = 4;
    localparam int CHANNELS   = 16;
    localparam int MAP_POINTS = 16;
    localparam int MAPS       = BOARDS * CHANNELS;

    // field widths
    localparam int MODE_W    = 2;
    localparam int BOARD_W   = 2;
    localparam int CHANNEL_W = 4;
    localparam int PIDX_W    = 4;
    localparam int PCNT_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int MAP_W     = $clog2(MAPS);
    localparam int ADDR_W    = MAP_W + PIDX_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int BIU_W      = 3;
    localparam int CIU_W      = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARDS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd1;
    localparam logic [BIU_W-1:0]     BOARDS_RESET   = 3'd4;
    localparam logic [CIU_W-1:0]     CHANNELS_RESET = 5'd16;

    // modes
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CORRECT = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PASS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLIP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd3;

    // point read selects
    localparam logic [2:0] RD_X0  = 3'd0;
    localparam logic [2:0] RD_XN  = 3'd1;
    localparam logic [2:0] RD_MID = 3'd2;
    localparam logic [2:0] RD_LO  = 3'd3;
    localparam logic [2:0] RD_HI  = 3'd4;

    // result selects
    localparam logic [2:0] RES_BAD    = 3'd0;
    localparam logic [2:0] RES_PASS   = 3'd1;
    localparam logic [2:0] RES_CLIP   = 3'd2;
    localparam logic [2:0] RES_LOWY   = 3'd3;
    localparam logic [2:0] RES_INTERP = 3'd4;

    typedef struct packed {
        logic       latch;
        logic       wr_point;
        logic       wr_count;
        logic       rd_len;
        logic       len_cap;
        logic       pt_rd;
        logic [2:0] rd_sel;
        logic       set_bounds;
        logic       upd_search;
        logic       cap_lo;
        logic       cap_hi;
        logic       mul;
        logic       div_step;
        logic       res_set;
        logic [2:0] res_sel;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              bad;
        logic              n_zero;
        logic              x_gt_s;
        logic              x_lt_s;
        logic              span;
        logic              den_zero;
        logic              div_last;
        logic              out_free;
    } t_stat;

endpackage
`default_nettype wire

// ----- hw/rtl/apc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_in_if
// Input channel: one command or sample transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
interface apc_in_if #(
    parameter int SAMPLE_WIDTH = 24
) ();
    logic                           valid;
    logic                           ready;
    logic [apc_pkg::MODE_W-1:0]     mode;
    logic [apc_pkg::BOARD_W-1:0]    board;
    logic [apc_pkg::CHANNEL_W-1:0]  channel;
    logic [apc_pkg::PIDX_W-1:0]     point_index;
    logic [apc_pkg::PCNT_W-1:0]     point_count;
    logic signed [SAMPLE_WIDTH-1:0] point_x;
    logic signed [SAMPLE_WIDTH-1:0] point_y;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, mode, board, channel, point_index, point_count,
                    point_x, point_y, sample, input ready);
    modport sink   (input valid, mode, board, channel, point_index, point_count,
                    point_x, point_y, sample, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/apc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_out_if
// Output channel: one corrected sample transaction per handshake.
// ----------------------------------------------------------------------------
interface apc_out_if #(
    parameter int SAMPLE_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_WIDTH-1:0] corrected;
    logic [apc_pkg::STATUS_W-1:0]   status;

    modport source (output valid, corrected, status, input ready);
    modport sink   (input valid, corrected, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/apc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/apc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_ctrl
// Sequencer: dispatches each transaction, walks the binary search, runs the
// serial divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module apc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire apc_pkg::t_stat i_stat,
    output logic                o_in_ready,
    output apc_pkg::t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_LEN  = 4'd2;
    localparam logic [3:0] S_X0   = 4'd3;
    localparam logic [3:0] S_XN   = 4'd4;
    localparam logic [3:0] S_SCHK = 4'd5;
    localparam logic [3:0] S_SRCH = 4'd6;
    localparam logic [3:0] S_RDL  = 4'd7;
    localparam logic [3:0] S_RDH  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_SUM  = 4'd11;
    localparam logic [3:0] S_RES  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.mode)
                    apc_pkg::MODE_WRITE: begin
                        o_cmd.wr_point = 1'b1;
                        n_state        = S_IDLE;
                    end
                    apc_pkg::MODE_COUNT: begin
                        o_cmd.wr_count = 1'b1;
                        n_state        = S_IDLE;
                    end
                    apc_pkg::MODE_CORRECT: begin
                        if (i_stat.bad) begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_sel = apc_pkg::RES_BAD;
                            n_state       = S_RES;
                        end else begin
                            o_cmd.rd_len = 1'b1;
                            n_state      = S_LEN;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_LEN: begin
                o_cmd.len_cap = 1'b1;
                if (i_stat.n_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = apc_pkg::RES_PASS;
                    n_state       = S_RES;
                end else begin
                    o_cmd.pt_rd  = 1'b1;
                    o_cmd.rd_sel = apc_pkg::RD_X0;
                    n_state      = S_X0;
                end
            end
            S_X0: begin
                if (i_stat.x_gt_s) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = apc_pkg::RES_PASS;
                    n_state       = S_RES;
                end else begin
                    o_cmd.pt_rd  = 1'b1;
                    o_cmd.rd_sel = apc_pkg::RD_XN;
                    n_state      = S_XN;
                end
            end
            S_XN: begin
                if (i_stat.x_lt_s) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = apc_pkg::RES_CLIP;
                    n_state       = S_RES;
                end else begin
                    o_cmd.set_bounds = 1'b1;
                    n_state          = S_SCHK;
                end
            end
            S_SCHK: begin
                o_cmd.pt_rd = 1'b1;
                if (i_stat.span) begin
                    o_cmd.rd_sel = apc_pkg::RD_MID;
                    n_state      = S_SRCH;
                end else begin
                    o_cmd.rd_sel = apc_pkg::RD_LO;
                    n_state      = S_RDL;
                end
            end
            S_SRCH: begin
                o_cmd.upd_search = 1'b1;
                n_state          = S_SCHK;
            end
            S_RDL: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.pt_rd  = 1'b1;
                o_cmd.rd_sel = apc_pkg::RD_HI;
                n_state      = S_RDH;
            end
            S_RDH: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                if (i_stat.den_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = apc_pkg::RES_LOWY;
                    n_state       = S_RES;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_sel = apc_pkg::RES_INTERP;
                n_state       = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/apc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_dp
// Datapath: configuration registers, map memories, search bounds, multiplier,
// restoring divider, saturation and output register.
// ----------------------------------------------------------------------------
module apc_dp #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire apc_pkg::t_cmd                     i_cmd,
    output apc_pkg::t_stat                         o_stat,
    input  wire logic [apc_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [apc_pkg::BOARD_W-1:0]       i_board,
    input  wire logic [apc_pkg::CHANNEL_W-1:0]     i_channel,
    input  wire logic [apc_pkg::PIDX_W-1:0]        i_point_index,
    input  wire logic [apc_pkg::PCNT_W-1:0]        i_point_count,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_point_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_point_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  wire logic                              i_cfg_we,
    input  wire logic [apc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [apc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]         o_corrected,
    output logic [apc_pkg::STATUS_W-1:0]           o_status
);
    localparam int SW   = SAMPLE_WIDTH;
    localparam int DW   = SW + 1;
    localparam int PW   = 2 * DW;
    localparam int SUMW = PW + 2;
    localparam int CW   = $clog2(PW + 1);
    localparam int PIW  = apc_pkg::PIDX_W;
    localparam logic signed [SUMW-1:0] SAT_TOP = {{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_BOT = ~SAT_TOP;

    // control registers
    logic [apc_pkg::BIU_W-1:0] r_biu;
    logic [apc_pkg::CIU_W-1:0] r_ciu;
    logic [apc_pkg::MAPS-1:0]  r_vld;
    logic                      r_ov;

    // payload registers
    logic [apc_pkg::MODE_W-1:0]    r_mode;
    logic [apc_pkg::BOARD_W-1:0]   r_board;
    logic [apc_pkg::CHANNEL_W-1:0] r_channel;
    logic [PIW-1:0]                r_pidx;
    logic [apc_pkg::PCNT_W-1:0]    r_pcnt;
    logic signed [SW-1:0]          r_px;
    logic signed [SW-1:0]          r_py;
    logic signed [SW-1:0]          r_s;
    logic                          r_len_vld;
    logic [apc_pkg::PCNT_W-1:0]    r_n;
    logic [PIW-1:0]                r_lo;
    logic [PIW-1:0]                r_hi;
    logic [PIW-1:0]                r_c;
    logic signed [SW-1:0]          r_xl;
    logic signed [SW-1:0]          r_yl;
    logic signed [SW-1:0]          r_xu;
    logic signed [SW-1:0]          r_yu;
    logic [DW-1:0]                 r_den;
    logic                          r_neg;
    logic [PW-1:0]                 r_dvd;
    logic [DW-1:0]                 r_rem;
    logic [PW-1:0]                 r_quo;
    logic [CW-1:0]                 r_cnt;
    logic signed [SW-1:0]          r_res;
    logic [apc_pkg::STATUS_W-1:0]  r_stat;
    logic signed [SW-1:0]          r_oc;
    logic [apc_pkg::STATUS_W-1:0]  r_os;

    logic                          w_inside;
    logic [apc_pkg::MAP_W-1:0]     w_map;
    logic [apc_pkg::PCNT_W-1:0]    w_len_q;
    logic [apc_pkg::PCNT_W-1:0]    w_n_eff;
    logic [apc_pkg::PCNT_W-1:0]    w_pcnt_sat;
    logic [2*SW-1:0]               w_pt_q;
    logic signed [SW-1:0]          w_xq;
    logic signed [SW-1:0]          w_yq;
    logic [PIW:0]                  w_mid_sum;
    logic [PIW-1:0]                w_mid;
    logic [PIW-1:0]                w_last;
    logic [PIW-1:0]                w_rd_idx;
    logic signed [DW-1:0]          w_dx;
    logic signed [DW-1:0]          w_dy;
    logic signed [DW-1:0]          w_dn;
    logic [DW-1:0]                 w_mdx;
    logic [DW-1:0]                 w_mdy;
    logic [DW-1:0]                 w_mdn;
    logic [PW-1:0]                 w_prod;
    logic [DW:0]                   w_rtry;
    logic                          w_qbit;
    logic signed [PW:0]            w_qmag;
    logic signed [PW:0]            w_qs;
    logic signed [SUMW-1:0]        w_sum;
    logic signed [SW-1:0]          w_clamp;

    // map addressing
    assign w_inside = (int'(r_board) < apc_pkg::BOARDS) && (int'(r_channel) < apc_pkg::CHANNELS);
    assign w_map    = apc_pkg::MAP_W'(int'(r_board) * apc_pkg::CHANNELS + int'(r_channel));
    assign w_pcnt_sat = (int'(r_pcnt) > apc_pkg::MAP_POINTS) ?
                        apc_pkg::PCNT_W'(apc_pkg::MAP_POINTS) : r_pcnt;
    assign w_n_eff  = r_len_vld ? w_len_q : '0;
    assign w_last   = PIW'(r_n - apc_pkg::PCNT_W'(1));
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_mid_sum[PIW:1];

    // point read index
    always_comb begin
        case (i_cmd.rd_sel)
            apc_pkg::RD_X0:  w_rd_idx = '0;
            apc_pkg::RD_XN:  w_rd_idx = w_last;
            apc_pkg::RD_MID: w_rd_idx = w_mid;
            apc_pkg::RD_LO:  w_rd_idx = r_lo;
            apc_pkg::RD_HI:  w_rd_idx = r_hi;
            default:         w_rd_idx = '0;
        endcase
    end

    // point memory, x in the upper half and y in the lower half
    apc_ram #(
        .WIDTH (2 * SW),
        .DEPTH (apc_pkg::MAPS * apc_pkg::MAP_POINTS)
    ) u_pt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_point && w_inside && (int'(r_pidx) < apc_pkg::MAP_POINTS)),
        .i_wr_addr ({w_map, r_pidx}),
        .i_wr_data ({r_px, r_py}),
        .i_rd_en   (i_cmd.pt_rd),
        .i_rd_addr ({w_map, w_rd_idx}),
        .o_rd_data (w_pt_q)
    );

    // map length memory
    apc_ram #(
        .WIDTH (apc_pkg::PCNT_W),
        .DEPTH (apc_pkg::MAPS)
    ) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_count && w_inside),
        .i_wr_addr (w_map),
        .i_wr_data (w_pcnt_sat),
        .i_rd_en   (i_cmd.rd_len),
        .i_rd_addr (w_map),
        .o_rd_data (w_len_q)
    );

    assign w_xq = $signed(w_pt_q[2*SW-1:SW]);
    assign w_yq = $signed(w_pt_q[SW-1:0]);

    // differences and magnitudes
    assign w_dx  = DW'(r_s) - DW'(r_xl);
    assign w_dy  = DW'(r_yu) - DW'(r_yl);
    assign w_dn  = DW'(r_xu) - DW'(r_xl);
    assign w_mdx = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_mdy = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    assign w_mdn = w_dn[DW-1] ? DW'(-w_dn) : DW'(w_dn);
    assign w_prod = PW'(w_mdx) * PW'(w_mdy);

    // restoring divider step
    assign w_rtry = {r_rem, r_dvd[PW-1]};
    assign w_qbit = (w_rtry >= {1'b0, r_den});

    // signed quotient plus lower y, saturated
    assign w_qmag = $signed({1'b0, r_quo});
    assign w_qs   = r_neg ? -w_qmag : w_qmag;
    assign w_sum  = SUMW'(w_qs) + SUMW'(r_yl);
    always_comb begin
        if (w_sum > SAT_TOP) begin
            w_clamp = SW'(SAT_TOP);
        end else if (w_sum < SAT_BOT) begin
            w_clamp = SW'(SAT_BOT);
        end else begin
            w_clamp = SW'(w_sum);
        end
    end

    // status to the controller
    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.bad      = !w_inside || (r_board >= r_biu) || (r_channel >= r_ciu);
        o_stat.n_zero   = (w_n_eff == '0);
        o_stat.x_gt_s   = (w_xq > r_s);
        o_stat.x_lt_s   = (w_xq < r_s);
        o_stat.span     = ((r_hi - r_lo) > PIW'(1));
        o_stat.den_zero = (r_xu == r_xl);
        o_stat.div_last = (r_cnt == CW'(1));
        o_stat.out_free = !r_ov || i_out_ready;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= apc_pkg::BOARDS_RESET;
            r_ciu <= apc_pkg::CHANNELS_RESET;
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == apc_pkg::CFG_BOARDS)) begin
                r_biu <= apc_pkg::BIU_W'(i_cfg_data);
            end
            if (i_cfg_we && (i_cfg_idx == apc_pkg::CFG_CHANNELS)) begin
                r_ciu <= apc_pkg::CIU_W'(i_cfg_data);
            end
            if (i_cmd.wr_count && w_inside) begin
                r_vld[w_map] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode    <= i_mode;
            r_board   <= i_board;
            r_channel <= i_channel;
            r_pidx    <= i_point_index;
            r_pcnt    <= i_point_count;
            r_px      <= i_point_x;
            r_py      <= i_point_y;
            r_s       <= i_sample;
        end
        if (i_cmd.rd_len) begin
            r_len_vld <= r_vld[w_map];
        end
        if (i_cmd.len_cap) begin
            r_n <= w_n_eff;
        end
        if (i_cmd.pt_rd && (i_cmd.rd_sel == apc_pkg::RD_MID)) begin
            r_c <= w_mid;
        end
        if (i_cmd.set_bounds) begin
            r_lo <= '0;
            r_hi <= w_last;
        end
        if (i_cmd.upd_search) begin
            if (w_xq > r_s) begin
                r_hi <= r_c;
            end else begin
                r_lo <= r_c;
            end
        end
        if (i_cmd.cap_lo) begin
            r_xl <= w_xq;
            r_yl <= w_yq;
        end
        if (i_cmd.cap_hi) begin
            r_xu <= w_xq;
            r_yu <= w_yq;
        end
        if (i_cmd.mul) begin
            r_dvd <= w_prod;
            r_rem <= '0;
            r_quo <= '0;
            r_den <= w_mdn;
            r_neg <= w_dx[DW-1] ^ w_dy[DW-1] ^ w_dn[DW-1];
            r_cnt <= CW'(PW);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? DW'(w_rtry - {1'b0, r_den}) : DW'(w_rtry);
            r_dvd <= {r_dvd[PW-2:0], 1'b0};
            r_quo <= {r_quo[PW-2:0], w_qbit};
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.res_set) begin
            case (i_cmd.res_sel)
                apc_pkg::RES_BAD: begin
                    r_res  <= '0;
                    r_stat <= apc_pkg::ST_BAD;
                end
                apc_pkg::RES_PASS: begin
                    r_res  <= r_s;
                    r_stat <= apc_pkg::ST_PASS;
                end
                apc_pkg::RES_CLIP: begin
                    r_res  <= w_yq;
                    r_stat <= apc_pkg::ST_CLIP;
                end
                apc_pkg::RES_LOWY: begin
                    r_res  <= r_yl;
                    r_stat <= apc_pkg::ST_INTERP;
                end
                apc_pkg::RES_INTERP: begin
                    r_res  <= w_clamp;
                    r_stat <= apc_pkg::ST_INTERP;
                end
                default: begin
                    r_res  <= '0;
                    r_stat <= apc_pkg::ST_BAD;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_oc <= r_res;
            r_os <= r_stat;
        end
    end

    assign o_out_valid = r_ov;
    assign o_corrected = r_oc;
    assign o_status    = r_os;
endmodule
`default_nettype wire

// ----- hw/rtl/adc_piecewise_linear_correction_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_piecewise_linear_correction_top
// Per-board, per-channel piecewise linear ADC correction with binary search
// and serial division.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. Map point writes and point count
// writes are done in the dispatch state. An interpolated corrected sample goes
// through up to four binary-search reads of the point memory, each a registered
// read followed by a compare, two reads of the bracketing points, a multiply
// and the one-bit-per-cycle restoring divider over 2*SAMPLE_WIDTH+2 quotient
// bits. Pass-through, clipped and flagged samples finish before the search.
// The finished result waits in an output register; a new transaction is taken
// while it waits, and the block stalls only when its next result is ready
// before the previous one is taken. Map lengths read as empty after reset with
// no clearing pass.
// ----------------------------------------------------------------------------
module adc_piecewise_linear_correction_top #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    apc_in_if.sink                              i_in,
    apc_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [apc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [apc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    apc_pkg::t_cmd  w_cmd;
    apc_pkg::t_stat w_stat;
    logic           w_ready;

    assign i_in.ready = w_ready;

    // sequencer
    apc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd)
    );

    // datapath
    apc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_mode        (i_in.mode),
        .i_board       (i_in.board),
        .i_channel     (i_in.channel),
        .i_point_index (i_in.point_index),
        .i_point_count (i_in.point_count),
        .i_point_x     (i_in.point_x),
        .i_point_y     (i_in.point_y),
        .i_sample      (i_in.sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_corrected   (o_out.corrected),
        .o_status      (o_out.status)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/apc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_checker
// Port-level assertions for the correction block, bound to the top level.
// ----------------------------------------------------------------------------
module apc_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [SAMPLE_WIDTH-1:0]       i_corrected,
    input wire logic [apc_pkg::STATUS_W-1:0]  i_status
);
    // one transaction at a time: ready drops after each accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted in back-to-back cycles");

    // flagged results carry zero
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == apc_pkg::ST_BAD) |-> (i_corrected == '0))
        else $error("flagged result with nonzero value");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_corrected) && $stable(i_status))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind adc_piecewise_linear_correction_top apc_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_apc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_corrected (o_out.corrected),
    .i_status    (o_out.status)
);
`default_nettype wire
